FILE: hw/rtl/nls_pkg.sv
// nls_pkg: shared types and constants of the nearest light selection block
// used by nls_front, nls_queue, nls_back and nearest_light_selection; depends on nothing

package nls_pkg;

    localparam int LIGHTS_DEF     = 64;
    localparam int NEAREST_DEF    = 8;
    localparam int COORD_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 2;

    localparam int FIELD_BITS = 24;
    localparam int SUM_BITS   = FIELD_BITS + 1;
    localparam int SLOT_BITS  = 6;
    localparam int ID_BITS    = 6;
    localparam int RANK_BITS  = 3;
    localparam int COUNT_BITS = 7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                         operation;
        logic [SLOT_BITS-1:0]         entry_index;
        logic signed [FIELD_BITS-1:0] first_x;
        logic signed [FIELD_BITS-1:0] first_y;
        logic signed [FIELD_BITS-1:0] first_z;
        logic signed [FIELD_BITS-1:0] second_x;
        logic signed [FIELD_BITS-1:0] second_y;
        logic signed [FIELD_BITS-1:0] second_z;
    } request_t;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [ID_BITS-1:0]   light_id;
        logic                 found;
        logic                 last;
    } response_t;

    // classified item: light position on load, corner sums on query
    typedef struct packed {
        logic                       is_query;
        logic                       slot_ok;
        logic [SLOT_BITS-1:0]       slot;
        logic signed [SUM_BITS-1:0] a_x;
        logic signed [SUM_BITS-1:0] a_y;
        logic signed [SUM_BITS-1:0] a_z;
    } work_t;

endpackage

FILE: hw/rtl/nls_ram.sv
// nls_ram: generic single write port, single read port ram with registered read
// no package dependency

module nls_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/nls_front.sv
// nls_front: accepts items, classifies loads and queries, forms corner sums
// depends on nls_pkg

module nls_front #(
    parameter int LIGHTS     = nls_pkg::LIGHTS_DEF,
    parameter int COORD_BITS = nls_pkg::COORD_BITS_DEF
) (
    input  logic              start,
    input  nls_pkg::request_t request,
    input  logic              queue_full,
    output logic              busy,
    output logic              push,
    output nls_pkg::work_t    work
);

    import nls_pkg::*;

    function automatic logic signed [SUM_BITS-1:0] sext(input logic [FIELD_BITS-1:0] f);
        logic signed [COORD_BITS-1:0] c;
        c = signed'(f[COORD_BITS-1:0]);
        return SUM_BITS'(c);
    endfunction

    logic is_query;

    assign busy     = queue_full;
    assign push     = start && !queue_full;
    assign is_query = (request.operation == OP_QUERY);

    always_comb
    begin
        work.is_query = is_query;
        work.slot_ok  = (32'(request.entry_index) < LIGHTS);
        work.slot     = request.entry_index;
        if (is_query)
        begin
            work.a_x = sext(request.first_x) + sext(request.second_x);
            work.a_y = sext(request.first_y) + sext(request.second_y);
            work.a_z = sext(request.first_z) + sext(request.second_z);
        end
        else
        begin
            work.a_x = sext(request.first_x);
            work.a_y = sext(request.first_y);
            work.a_z = sext(request.first_z);
        end
    end

endmodule

FILE: hw/rtl/nls_queue.sv
// nls_queue: short fifo of classified items between front and back
// depends on nls_pkg

module nls_queue #(
    parameter int DEPTH = nls_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nls_pkg::work_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output nls_pkg::work_t head
);

    import nls_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    work_t           entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic            do_pop;

    assign full      = (fill_reg == FW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/nls_back.sv
// nls_back: carries out loads and queries, scans the light table through a
// distance pipeline and keeps a sorted nearest list; depends on nls_pkg, nls_ram

module nls_back #(
    parameter int LIGHTS     = nls_pkg::LIGHTS_DEF,
    parameter int NEAREST    = nls_pkg::NEAREST_DEF,
    parameter int COORD_BITS = nls_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [nls_pkg::COUNT_BITS-1:0]   light_count,
    input  logic                             work_valid,
    input  nls_pkg::work_t                   work,
    output logic                             pop,
    output nls_pkg::response_t               response,
    output logic                             response_strobe
);

    import nls_pkg::*;

    localparam int AW  = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int CW  = $clog2(LIGHTS + 1);
    localparam int KW  = (NEAREST > 1) ? $clog2(NEAREST) : 1;
    localparam int CB  = COORD_BITS;
    localparam int DFW = CB + 3;
    localparam int AXW = CB + 2;
    localparam int SQW = 2 * AXW;
    localparam int DW  = SQW + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CW-1:0]        iss_reg;
    logic [CW-1:0]        count_reg;
    logic [KW-1:0]        emit_reg;
    logic signed [CB:0]   sum_x_reg;
    logic signed [CB:0]   sum_y_reg;
    logic signed [CB:0]   sum_z_reg;

    logic                 v_rd_reg;
    logic                 v_abs_reg;
    logic                 v_sq_reg;
    logic                 v_dist_reg;
    logic [AW-1:0]        idx_rd_reg;
    logic [AW-1:0]        idx_abs_reg;
    logic [AW-1:0]        idx_sq_reg;
    logic [AW-1:0]        idx_dist_reg;
    logic [AXW-1:0]       abs_x_reg;
    logic [AXW-1:0]       abs_y_reg;
    logic [AXW-1:0]       abs_z_reg;
    logic [SQW-1:0]       sq_x_reg;
    logic [SQW-1:0]       sq_y_reg;
    logic [SQW-1:0]       sq_z_reg;
    logic [DW-1:0]        dist_reg;

    logic [DW-1:0]        best_d_reg  [NEAREST];
    logic [ID_BITS-1:0]   best_id_reg [NEAREST];

    response_t            response_reg;
    logic                 strobe_reg;

    logic [CW-1:0]        count_now;
    logic                 issue;
    logic                 scan_done;
    logic                 last_now;
    logic [NEAREST-1:0]   lt;
    logic [3*CB-1:0]      rd_data;
    logic [AXW-1:0]       abs_x;
    logic [AXW-1:0]       abs_y;
    logic [AXW-1:0]       abs_z;

    function automatic logic [AXW-1:0] axis_abs(input logic [CB-1:0] pos,
                                                input logic [CB:0] sum);
        logic [DFW-1:0] d;
        logic [DFW-1:0] n;
        d = {pos[CB-1], pos[CB-1], pos, 1'b0} - {sum[CB], sum[CB], sum};
        n = ~d + 1'b1;
        return d[DFW-1] ? n[AXW-1:0] : d[AXW-1:0];
    endfunction

    assign count_now = (32'(light_count) > LIGHTS) ? CW'(LIGHTS) : CW'(light_count);
    assign pop       = (state_reg == ST_IDLE) && work_valid;
    assign issue     = (state_reg == ST_SCAN) && (iss_reg < count_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issue && !v_rd_reg && !v_abs_reg
                       && !v_sq_reg && !v_dist_reg;
    assign last_now  = (32'(emit_reg) == NEAREST - 1)
                       || (32'(emit_reg) + 32'd1 == 32'(count_reg));

    assign response        = response_reg;
    assign response_strobe = strobe_reg;

    nls_ram #(
        .WIDTH (3 * CB),
        .DEPTH (LIGHTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (pop && !work.is_query && work.slot_ok),
        .wr_addr (AW'(work.slot)),
        .wr_data ({work.a_x[CB-1:0], work.a_y[CB-1:0], work.a_z[CB-1:0]}),
        .rd_en   (issue),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign abs_x = axis_abs(rd_data[3*CB-1:2*CB], sum_x_reg);
    assign abs_y = axis_abs(rd_data[2*CB-1:CB], sum_y_reg);
    assign abs_z = axis_abs(rd_data[CB-1:0], sum_z_reg);

    always_comb
    begin
        for (int k = 0; k < NEAREST; k++)
        begin
            lt[k] = (dist_reg < best_d_reg[k]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && work.is_query && (count_now != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (last_now)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            iss_reg    <= '0;
            count_reg  <= '0;
            emit_reg   <= '0;
            v_rd_reg   <= 1'b0;
            v_abs_reg  <= 1'b0;
            v_sq_reg   <= 1'b0;
            v_dist_reg <= 1'b0;
            strobe_reg <= 1'b0;
            for (int k = 0; k < NEAREST; k++)
            begin
                best_d_reg[k]  <= '1;
                best_id_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            v_rd_reg   <= issue;
            v_abs_reg  <= v_rd_reg;
            v_sq_reg   <= v_abs_reg;
            v_dist_reg <= v_sq_reg;
            strobe_reg <= 1'b0;

            if (issue)
            begin
                iss_reg <= iss_reg + 1'b1;
            end

            if (pop && work.is_query)
            begin
                count_reg <= count_now;
                iss_reg   <= '0;
                emit_reg  <= '0;
                if (count_now == '0)
                begin
                    strobe_reg <= 1'b1;
                end
                for (int k = 0; k < NEAREST; k++)
                begin
                    best_d_reg[k]  <= '1;
                    best_id_reg[k] <= '0;
                end
            end

            // insertion keeps the list sorted, ties stay behind
            if (v_dist_reg)
            begin
                for (int k = 0; k < NEAREST; k++)
                begin
                    if (lt[k] && (k == 0 || !lt[(k == 0) ? 0 : k - 1]))
                    begin
                        best_d_reg[k]  <= dist_reg;
                        best_id_reg[k] <= ID_BITS'(idx_dist_reg);
                    end
                    else if (k > 0 && lt[(k == 0) ? 0 : k - 1])
                    begin
                        best_d_reg[k]  <= best_d_reg[(k == 0) ? 0 : k - 1];
                        best_id_reg[k] <= best_id_reg[(k == 0) ? 0 : k - 1];
                    end
                end
            end

            if (state_reg == ST_EMIT)
            begin
                strobe_reg <= 1'b1;
                emit_reg   <= emit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && work.is_query)
        begin
            sum_x_reg <= work.a_x[CB:0];
            sum_y_reg <= work.a_y[CB:0];
            sum_z_reg <= work.a_z[CB:0];
            response_reg.rank     <= '0;
            response_reg.light_id <= '0;
            response_reg.found    <= 1'b0;
            response_reg.last     <= 1'b1;
        end
        if (state_reg == ST_EMIT)
        begin
            response_reg.rank     <= RANK_BITS'(emit_reg);
            response_reg.light_id <= best_id_reg[emit_reg];
            response_reg.found    <= 1'b1;
            response_reg.last     <= last_now;
        end
        idx_rd_reg   <= iss_reg[AW-1:0];
        idx_abs_reg  <= idx_rd_reg;
        idx_sq_reg   <= idx_abs_reg;
        idx_dist_reg <= idx_sq_reg;
        abs_x_reg    <= abs_x;
        abs_y_reg    <= abs_y;
        abs_z_reg    <= abs_z;
        sq_x_reg     <= abs_x_reg * abs_x_reg;
        sq_y_reg     <= abs_y_reg * abs_y_reg;
        sq_z_reg     <= abs_z_reg * abs_z_reg;
        dist_reg     <= DW'(sq_x_reg) + DW'(sq_y_reg) + DW'(sq_z_reg);
    end

`ifndef SYNTH
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (v_rd_reg || v_abs_reg || v_sq_reg || v_dist_reg) |-> state_reg == ST_SCAN)
        else $error("distance pipeline busy outside a scan");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> iss_reg <= count_reg)
        else $error("scan index ran past the light count");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && response_reg.last) |-> state_reg == ST_IDLE)
        else $error("last result shown while query still running");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !pop)
        else $error("item taken from queue while back end busy");
`endif

endmodule

FILE: hw/rtl/nearest_light_selection.sv
// nearest_light_selection: top level, configuration register and wiring
// depends on nls_pkg, nls_front, nls_queue, nls_back, nls_ram

// A load item writes one light position and leaves the back end idle. In a
// query the scan reads one table entry per cycle through the single read
// port of the light table and a four stage distance pipeline, then results
// follow one per cycle, closest first, one strobe each, with no way for the
// receiver to stall them. A two entry queue lets start be accepted while a
// query is still running; busy is high only when that queue is full.
// light_count may be written at any time the block is idle; cfg_ready is
// always high.

module nearest_light_selection #(
    parameter int LIGHTS     = nls_pkg::LIGHTS_DEF,
    parameter int NEAREST    = nls_pkg::NEAREST_DEF,
    parameter int COORD_BITS = nls_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nls_pkg::request_t              request,
    output nls_pkg::response_t             response,
    output logic                           response_strobe,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nls_pkg::COUNT_BITS-1:0] cfg_data
);

    import nls_pkg::*;

    logic [COUNT_BITS-1:0] light_count_reg;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_valid;
    work_t                 front_work;
    work_t                 queue_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            light_count_reg <= cfg_data;
        end
    end

    nls_front #(
        .LIGHTS     (LIGHTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .start      (start),
        .request    (request),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .work       (front_work)
    );

    nls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_work),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head      (queue_head)
    );

    nls_back #(
        .LIGHTS     (LIGHTS),
        .NEAREST    (NEAREST),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .light_count     (light_count_reg),
        .work_valid      (queue_valid),
        .work            (queue_head),
        .pop             (pop),
        .response        (response),
        .response_strobe (response_strobe)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of nearest_light_selection, a directed start then random loads and queries
// depends on nls_pkg and nearest_light_selection; predicts the ranked light ids of every query itself

module tb;
    import nls_pkg::*;

    localparam int SLOTS        = LIGHTS_DEF;
    localparam int TOP_N        = NEAREST_DEF;
    localparam int DRAIN_CYCLES = 2 * (LIGHTS_DEF + 6 + NEAREST_DEF);
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [FIELD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [FIELD_BITS-1:0] COORD_MIN = 24'sh800000;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    request_t              request = '0;
    response_t             response;
    logic                  response_strobe;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_BITS-1:0] cfg_data = '0;

    request_t  pending_items[$];
    response_t ranked_due[$];
    response_t due;

    logic signed [FIELD_BITS-1:0] light_x[SLOTS];
    logic signed [FIELD_BITS-1:0] light_y[SLOTS];
    logic signed [FIELD_BITS-1:0] light_z[SLOTS];
    logic [COUNT_BITS-1:0]        lights_in_use = '0;

    int gap_left        = 0;
    bit steady_flow     = 1'b0;
    int fail_count      = 0;
    int loads_seen      = 0;
    int queries_seen    = 0;
    int results_checked = 0;
    int settings_used   = 0;

    nearest_light_selection i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .response        (response),
        .response_strobe (response_strobe),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic [53:0] axis_reach(input logic signed [FIELD_BITS-1:0] pos,
                                               input logic signed [FIELD_BITS-1:0] lo,
                                               input logic signed [FIELD_BITS-1:0] hi);
        longint d;
        d = 2 * longint'(pos) - (longint'(lo) + longint'(hi));
        if (d < 0)
            d = -d;
        return 54'(d * d);
    endfunction

    // table update on load, ranked light ids on query
    task automatic rank_lights(input request_t r);
        logic [53:0]        near_reach[TOP_N];
        logic [ID_BITS-1:0] near_id[TOP_N];
        logic [53:0]        reach;
        response_t          res;
        int                 slot_at;
        int                 span;
        int                 shown;
        if (r.operation == OP_LOAD)
        begin
            light_x[r.entry_index] = r.first_x;
            light_y[r.entry_index] = r.first_y;
            light_z[r.entry_index] = r.first_z;
            loads_seen++;
            return;
        end
        queries_seen++;
        span = (lights_in_use > SLOTS) ? SLOTS : int'(lights_in_use);
        res = '0;
        if (span == 0)
        begin
            res.last = 1'b1;
            ranked_due.push_back(res);
            return;
        end
        for (int k = 0; k < TOP_N; k++)
        begin
            near_reach[k] = '1;
            near_id[k]    = '0;
        end
        for (int i = 0; i < span; i++)
        begin
            reach = axis_reach(light_x[i], r.first_x, r.second_x)
                  + axis_reach(light_y[i], r.first_y, r.second_y)
                  + axis_reach(light_z[i], r.first_z, r.second_z);
            slot_at = TOP_N;
            for (int k = 0; k < TOP_N; k++)
            begin
                if (reach < near_reach[k])
                begin
                    slot_at = k;
                    break;
                end
            end
            if (slot_at < TOP_N)
            begin
                for (int k = TOP_N - 1; k > slot_at; k--)
                begin
                    near_reach[k] = near_reach[k-1];
                    near_id[k]    = near_id[k-1];
                end
                near_reach[slot_at] = reach;
                near_id[slot_at]    = ID_BITS'(i);
            end
        end
        shown = (span < TOP_N) ? span : TOP_N;
        for (int k = 0; k < shown; k++)
        begin
            res.rank     = RANK_BITS'(k);
            res.light_id = near_id[k];
            res.found    = 1'b1;
            res.last     = (k + 1 == shown);
            ranked_due.push_back(res);
        end
    endtask

    function automatic int next_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (steady_flow || pick < 12)
            return 0;
        if (pick < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                rank_lights(request);
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    start    <= 1'b1;
                    request  <= pending_items.pop_front();
                    gap_left <= next_gap();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (rst_n && response_strobe)
        begin
            if (ranked_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result rank %0d light %0d",
                                          response.rank, response.light_id));
            end
            else
            begin
                due = ranked_due.pop_front();
                results_checked++;
                if (response.rank !== due.rank)
                    report_mismatch($sformatf("rank %0d, expected %0d", response.rank, due.rank));
                if (response.light_id !== due.light_id)
                    report_mismatch($sformatf("rank %0d light_id %0d, expected %0d",
                                              due.rank, response.light_id, due.light_id));
                if (response.found !== due.found)
                    report_mismatch($sformatf("rank %0d found %b, expected %b",
                                              due.rank, response.found, due.found));
                if (response.last !== due.last)
                    report_mismatch($sformatf("rank %0d last %b, expected %b",
                                              due.rank, response.last, due.last));
            end
        end
    end

    function automatic logic signed [FIELD_BITS-1:0] random_coord();
        logic signed [FIELD_BITS-1:0] v;
        int                           pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = FIELD_BITS'(int'($urandom_range(0, 16)) - 8);
        else if (pick < 8)
            v = FIELD_BITS'($urandom);
        else
        begin
            case ($urandom_range(0, 4))
                0:       v = COORD_MAX;
                1:       v = COORD_MIN;
                2:       v = '0;
                3:       v = '1;
                default: v = 24'sd1;
            endcase
        end
        return v;
    endfunction

    function automatic request_t random_item(input int query_pct);
        request_t r;
        r.operation   = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_LOAD;
        r.entry_index = SLOT_BITS'($urandom);
        r.first_x     = random_coord();
        r.first_y     = random_coord();
        r.first_z     = random_coord();
        r.second_x    = random_coord();
        r.second_y    = random_coord();
        r.second_z    = random_coord();
        // point sized box now and then
        if (r.operation == OP_QUERY && $urandom_range(0, 2) == 0)
        begin
            r.second_x = r.first_x;
            r.second_y = r.first_y;
            r.second_z = r.first_z;
        end
        return r;
    endfunction

    function automatic request_t light_item(input int slot,
                                            input logic signed [FIELD_BITS-1:0] x,
                                            input logic signed [FIELD_BITS-1:0] y,
                                            input logic signed [FIELD_BITS-1:0] z);
        request_t r;
        r             = random_item(0);
        r.entry_index = SLOT_BITS'(slot);
        r.first_x     = x;
        r.first_y     = y;
        r.first_z     = z;
        return r;
    endfunction

    function automatic request_t box_item(input logic signed [FIELD_BITS-1:0] lx,
                                          input logic signed [FIELD_BITS-1:0] ly,
                                          input logic signed [FIELD_BITS-1:0] lz,
                                          input logic signed [FIELD_BITS-1:0] hx,
                                          input logic signed [FIELD_BITS-1:0] hy,
                                          input logic signed [FIELD_BITS-1:0] hz);
        request_t r;
        r           = random_item(100);
        r.first_x   = lx;
        r.first_y   = ly;
        r.first_z   = lz;
        r.second_x  = hx;
        r.second_y  = hy;
        r.second_z  = hz;
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || start || ranked_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_light_count(input logic [COUNT_BITS-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        lights_in_use  = value;
        settings_used++;
        steady_flow    = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        int slot_order[$];
        int j;
        int tmp;
        int counts[8];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // no lights, then a small table with ties and extreme positions
        set_light_count(0);
        pending_items.push_back(box_item(COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MAX, COORD_MAX, COORD_MAX));
        pending_items.push_back(light_item(0, COORD_MAX, COORD_MAX, COORD_MAX));
        pending_items.push_back(light_item(1, COORD_MIN, COORD_MIN, COORD_MIN));
        pending_items.push_back(light_item(2, 0, 0, 0));
        pending_items.push_back(light_item(3, 0, 0, 0));
        pending_items.push_back(light_item(4, 256, -256, 512));
        pending_items.push_back(light_item(5, -1, 1, -1));
        pending_items.push_back(light_item(6, 1000, 1000, 1000));
        pending_items.push_back(light_item(7, -5000, 7, 3));
        pending_items.push_back(light_item(8, 0, 0, 0));
        pending_items.push_back(light_item(9, 100, -100, 50));
        pending_items.push_back(light_item(SLOTS - 1, random_coord(), random_coord(),
                                           random_coord()));
        pending_items.push_back(box_item(0, 0, 0, 0, 0, 0));

        set_light_count(1);
        pending_items.push_back(box_item(0, 0, 0, 0, 0, 0));

        // fewer lights than result slots
        set_light_count(3);
        pending_items.push_back(box_item(-2, -2, -2, 2, 2, 2));
        pending_items.push_back(box_item(COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MAX, COORD_MAX, COORD_MAX));

        set_light_count(TOP_N);
        pending_items.push_back(box_item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(box_item(COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MIN, COORD_MIN, COORD_MIN));

        set_light_count(10);
        pending_items.push_back(box_item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(box_item(COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MIN, COORD_MIN, COORD_MIN));
        pending_items.push_back(random_item(100));

        // fill the rest of the table in random order, querying the loaded prefix meanwhile
        set_light_count(COUNT_BITS'($urandom_range(1, 10)));
        for (int s = 10; s < SLOTS; s++)
            slot_order.push_back(s);
        for (int i = slot_order.size() - 1; i > 0; i--)
        begin
            j             = $urandom_range(0, i);
            tmp           = slot_order[i];
            slot_order[i] = slot_order[j];
            slot_order[j] = tmp;
        end
        foreach (slot_order[i])
        begin
            pending_items.push_back(light_item(slot_order[i], random_coord(), random_coord(),
                                               random_coord()));
            if ($urandom_range(0, 9) < 3)
                pending_items.push_back(random_item(100));
        end

        // whole table loaded: any count is legal now, saturation included
        counts = '{127, SLOTS, SLOTS + 1, 0, TOP_N, 1, $urandom_range(0, 127),
                   $urandom_range(2, 20)};
        foreach (counts[p])
        begin
            set_light_count(COUNT_BITS'(counts[p]));
            repeat (38) pending_items.push_back(random_item(45));
        end

        wait_idle();
        $display("covered %0d loads and %0d queries over %0d light_count settings",
                 loads_seen, queries_seen, settings_used);
        $display("%0d result items checked", results_checked);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
